### design/lghd_pkg.sv
// Shared types, constants and the palette white table for the light gun hit detector.
package lghd_pkg;

  localparam int WINDOW_HALF   = 8;
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 240;

  localparam int COORD_W = 12;
  localparam int COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 9'd64;

  localparam logic [7:0] STATUS_TRIGGER  = 8'h10;
  localparam logic [7:0] STATUS_NO_LIGHT = 8'h08;

  localparam logic [63:0] WHITE_MASK = 64'h3FFF_3FFF_1FFF_0001;

  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_AIM       = 3'd1,
    KIND_TRIGGER   = 3'd2,
    KIND_READ      = 3'd3,
    KIND_FRAME_END = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [5:0]        palette_index;
    logic signed [9:0] aim_x;
    logic signed [9:0] aim_y;
    logic              trigger_held;
    logic              rendering_enabled;
  } item_t;

  function automatic logic is_white(input logic [5:0] idx);
    return WHITE_MASK[idx];
  endfunction

  function automatic logic in_window(input logic [7:0] p, input logic signed [9:0] c);
    logic signed [COORD_W-1:0] ps;
    logic signed [COORD_W-1:0] cs;
    ps = $signed({{(COORD_W-8){1'b0}}, p});
    cs = COORD_W'(c);
    return (ps >= cs - COORD_W'(WINDOW_HALF)) && (ps < cs + COORD_W'(WINDOW_HALF));
  endfunction

endpackage

### design/lghd_in_reg.sv
// Input register stage that holds one item until the core takes it.
module lghd_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lghd_pkg::item_t      in_item,
  input  logic                 advance,
  output logic                 item_valid,
  output lghd_pkg::item_t      item
);

  logic            valid_r;
  logic            valid_nxt;
  lghd_pkg::item_t item_r;

  assign in_stall   = valid_r && !advance;
  assign valid_nxt  = in_stall ? valid_r : in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

### design/lghd_core.sv
// Detector state, per-item evaluation and the status result register.
module lghd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  lghd_pkg::item_t      item,
  output logic                 advance,
  input  logic                 cfg_valid,
  input  logic [8:0]           cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_read_data,
  output logic                 out_light_seen
);

  logic signed [9:0]                aim_col_r,   aim_col_nxt;
  logic signed [9:0]                aim_row_r,   aim_row_nxt;
  logic [lghd_pkg::COUNT_W-1:0]     run_cnt_r,   run_cnt_nxt;
  logic [lghd_pkg::COUNT_W-1:0]     frame_cnt_r, frame_cnt_nxt;
  logic                             trig_r,      trig_nxt;
  logic [lghd_pkg::COUNT_W-1:0]     thresh_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       data_r,      data_nxt;
  logic                             light_r,     light_nxt;

  logic fire;
  logic pix_hit;
  logic aim_on;
  logic light;

  assign advance = !(out_valid_r && out_stall);
  assign fire    = item_valid && advance;

  assign pix_hit = ({4'd0, item.pixel_x} < 12'(lghd_pkg::SCREEN_WIDTH)) &&
                   ({4'd0, item.pixel_y} < 12'(lghd_pkg::SCREEN_HEIGHT)) &&
                   lghd_pkg::in_window(item.pixel_x, aim_col_r) &&
                   lghd_pkg::in_window(item.pixel_y, aim_row_r) &&
                   lghd_pkg::is_white(item.palette_index);

  assign aim_on = !aim_col_r[9] && !aim_row_r[9] &&
                  (12'(aim_col_r) < 12'(lghd_pkg::SCREEN_WIDTH)) &&
                  (12'(aim_row_r) < 12'(lghd_pkg::SCREEN_HEIGHT));

  assign light = aim_on && item.rendering_enabled && (frame_cnt_r > thresh_r);

  always_comb begin
    aim_col_nxt   = aim_col_r;
    aim_row_nxt   = aim_row_r;
    run_cnt_nxt   = run_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    trig_nxt      = trig_r;
    out_valid_nxt = advance ? 1'b0 : out_valid_r;
    data_nxt      = data_r;
    light_nxt     = light_r;
    if (fire) begin
      case (item.kind)
        lghd_pkg::KIND_PIXEL: begin
          if (pix_hit && run_cnt_r != lghd_pkg::COUNT_MAX) begin
            run_cnt_nxt = run_cnt_r + 1'b1;
          end
        end
        lghd_pkg::KIND_AIM: begin
          aim_col_nxt = item.aim_x;
          aim_row_nxt = item.aim_y;
        end
        lghd_pkg::KIND_TRIGGER: begin
          trig_nxt = item.trigger_held;
        end
        lghd_pkg::KIND_READ: begin
          out_valid_nxt = 1'b1;
          data_nxt      = (trig_r ? lghd_pkg::STATUS_TRIGGER : 8'h00) |
                          (light ? 8'h00 : lghd_pkg::STATUS_NO_LIGHT);
          light_nxt     = light;
        end
        lghd_pkg::KIND_FRAME_END: begin
          frame_cnt_nxt = run_cnt_r;
          run_cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_col_r   <= '0;
      aim_row_r   <= '0;
      run_cnt_r   <= '0;
      frame_cnt_r <= '0;
      trig_r      <= 1'b0;
      thresh_r    <= lghd_pkg::THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      aim_col_r   <= aim_col_nxt;
      aim_row_r   <= aim_row_nxt;
      run_cnt_r   <= run_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      trig_r      <= trig_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    light_r <= light_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = data_r;
  assign out_light_seen = light_r;

endmodule

### design/light_gun_hit_detector.sv
// Top level of the light gun hit detector.
// One item is accepted every cycle unless the input stalls: pixels, aim updates, trigger
// changes, frame ends and status reads all pass through an input register and a single
// evaluation step into the result register, so the sustained rate is one item per clock
// while no result is held. Only a read produces a result; a held result stalls the input
// only once the input register is also occupied. The threshold register is always ready
// and should be written while no item is in flight.
module light_gun_hit_detector (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_pixel_x,
  input  logic [7:0]        in_pixel_y,
  input  logic [5:0]        in_palette_index,
  input  logic signed [9:0] in_aim_x,
  input  logic signed [9:0] in_aim_y,
  input  logic              in_trigger_held,
  input  logic              in_rendering_enabled,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_data,
  output logic              out_light_seen
);

  lghd_pkg::item_t in_item;
  lghd_pkg::item_t item;
  logic            item_valid;
  logic            advance;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.kind              = lghd_pkg::kind_t'(in_kind);
    in_item.pixel_x           = in_pixel_x;
    in_item.pixel_y           = in_pixel_y;
    in_item.palette_index     = in_palette_index;
    in_item.aim_x             = in_aim_x;
    in_item.aim_y             = in_aim_y;
    in_item.trigger_held      = in_trigger_held;
    in_item.rendering_enabled = in_rendering_enabled;
  end

  lghd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lghd_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .advance        (advance),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_light_seen (out_light_seen)
  );

endmodule

### design/lghd_checker.sv
// Port-level checker for the light gun hit detector and its bind.
module lghd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_light_seen
);

  a_no_light_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data[3] == !out_light_seen))
    else $error("Status no-light bit disagrees with light_seen.");

  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_read_data & 8'hE7) == 8'h00))
    else $error("Status byte has bits set outside trigger and no-light.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Result or stall present right after reset.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_light_seen))
    else $error("Stalled result changed.");

endmodule

bind light_gun_hit_detector lghd_checker u_lghd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_light_seen (out_light_seen)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the light gun hit detector: directed table, then random frames.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;
  localparam logic [63:0] WHITE_PALETTE    = {16'h3FFF, 16'h3FFF, 16'h1FFF, 16'h0001};
  localparam int NUM_ROWS        = 24;
  localparam int IDLE_HEAVY      = 84;
  localparam int IDLE_BOTH       = 30;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        px;
    logic [7:0]        py;
    logic [5:0]        pal;
    logic signed [9:0] ax;
    logic signed [9:0] ay;
    logic              trig;
    logic              rend;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       light;
  } status_t;

  typedef struct {
    stim_t      s;
    bit         typed;
    logic [7:0] data;
    logic       light;
  } row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_kind = '0;
  logic [7:0]        in_pixel_x = '0;
  logic [7:0]        in_pixel_y = '0;
  logic [5:0]        in_palette_index = '0;
  logic signed [9:0] in_aim_x = '0;
  logic signed [9:0] in_aim_y = '0;
  logic              in_trigger_held = 1'b0;
  logic              in_rendering_enabled = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [8:0]        cfg_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_read_data;
  logic              out_light_seen;

  light_gun_hit_detector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_pixel_x           (in_pixel_x),
    .in_pixel_y           (in_pixel_y),
    .in_palette_index     (in_palette_index),
    .in_aim_x             (in_aim_x),
    .in_aim_y             (in_aim_y),
    .in_trigger_held      (in_trigger_held),
    .in_rendering_enabled (in_rendering_enabled),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_data        (out_read_data),
    .out_light_seen       (out_light_seen)
  );

  logic signed [9:0] cur_aim_x = '0;
  logic signed [9:0] cur_aim_y = '0;
  logic [8:0]        pixel_tally = '0;
  logic [8:0]        latched_tally = '0;
  logic              trigger_down = 1'b0;
  logic [8:0]        hit_limit = lghd_pkg::THRESHOLD_RESET;

  status_t     status_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit predict_status(input stim_t s, output status_t res);
    int ax;
    int ay;
    bit lit;
    ax = cur_aim_x;
    ay = cur_aim_y;
    res = '0;
    case (s.kind)
      lghd_pkg::KIND_PIXEL: begin
        if (int'(s.px) < lghd_pkg::SCREEN_WIDTH && int'(s.py) < lghd_pkg::SCREEN_HEIGHT &&
            int'(s.px) >= ax - lghd_pkg::WINDOW_HALF &&
            int'(s.px) < ax + lghd_pkg::WINDOW_HALF &&
            int'(s.py) >= ay - lghd_pkg::WINDOW_HALF &&
            int'(s.py) < ay + lghd_pkg::WINDOW_HALF &&
            WHITE_PALETTE[s.pal] && pixel_tally != lghd_pkg::COUNT_MAX)
          pixel_tally++;
      end
      lghd_pkg::KIND_AIM: begin
        cur_aim_x = s.ax;
        cur_aim_y = s.ay;
      end
      lghd_pkg::KIND_TRIGGER: trigger_down = s.trig;
      lghd_pkg::KIND_READ: begin
        lit = ax >= 0 && ax < lghd_pkg::SCREEN_WIDTH && ay >= 0 &&
              ay < lghd_pkg::SCREEN_HEIGHT && s.rend && latched_tally > hit_limit;
        res.data = (trigger_down ? lghd_pkg::STATUS_TRIGGER : 8'h00) |
                   (lit ? 8'h00 : lghd_pkg::STATUS_NO_LIGHT);
        res.light = lit;
        return 1'b1;
      end
      lghd_pkg::KIND_FRAME_END: begin
        latched_tally = pixel_tally;
        pixel_tally = '0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic stim_t random_fields();
    logic [63:0] r;
    stim_t s;
    r = {$urandom, $urandom};
    s = r[$bits(stim_t)-1:0];
    return s;
  endfunction

  function automatic stim_t pixel_item(input logic [7:0] x, input logic [7:0] y,
                                       input logic [5:0] pal);
    stim_t s;
    s = random_fields();
    s.kind = lghd_pkg::KIND_PIXEL;
    s.px = x;
    s.py = y;
    s.pal = pal;
    return s;
  endfunction

  function automatic stim_t aim_item(input logic signed [9:0] x, input logic signed [9:0] y);
    stim_t s;
    s = random_fields();
    s.kind = lghd_pkg::KIND_AIM;
    s.ax = x;
    s.ay = y;
    return s;
  endfunction

  function automatic stim_t trigger_item(input logic held);
    stim_t s;
    s = random_fields();
    s.kind = lghd_pkg::KIND_TRIGGER;
    s.trig = held;
    return s;
  endfunction

  function automatic stim_t read_item(input logic rend);
    stim_t s;
    s = random_fields();
    s.kind = lghd_pkg::KIND_READ;
    s.rend = rend;
    return s;
  endfunction

  function automatic stim_t frame_end_item();
    stim_t s;
    s = random_fields();
    s.kind = lghd_pkg::KIND_FRAME_END;
    return s;
  endfunction

  function automatic stim_t spare_item(input logic [2:0] kind);
    stim_t s;
    s = random_fields();
    s.kind = kind;
    return s;
  endfunction

  function automatic stim_t near_pixel(input int ax, input int ay);
    return pixel_item(8'(ax + int'($urandom_range(17, 0)) - 9),
                      8'(ay + int'($urandom_range(17, 0)) - 9), 6'($urandom_range(63, 0)));
  endfunction

  function automatic row_t quiet_row(input stim_t s);
    row_t r;
    r.s = s;
    r.typed = 1'b0;
    r.data = '0;
    r.light = 1'b0;
    return r;
  endfunction

  function automatic row_t known_read(input logic rend, input logic [7:0] data,
                                      input logic light);
    row_t r;
    r.s = read_item(rend);
    r.typed = 1'b1;
    r.data = data;
    r.light = light;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_item(input stim_t s, input bit typed = 1'b0,
                           input logic [7:0] typed_data = '0, input logic typed_light = 1'b0);
    status_t want;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_pixel_x <= s.px;
    in_pixel_y <= s.py;
    in_palette_index <= s.pal;
    in_aim_x <= s.ax;
    in_aim_y <= s.ay;
    in_trigger_held <= s.trig;
    in_rendering_enabled <= s.rend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_status(s, want)) begin
      if (typed) want = '{typed_data, typed_light};
      status_q.push_back(want);
    end
    if (s.kind <= lghd_pkg::KIND_FRAME_END) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [8:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hit_limit = value;
  endtask

  // Frames of aim, mostly windowed pixels and a frame end, followed by reads,
  // with reads, trigger changes, aim moves and spare codes mixed in.
  task automatic run_frames(input int quota);
    int start;
    int ax;
    int ay;
    int n;
    int k;
    int pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(9, 0) < 8) begin
        ax = $urandom_range(255, 0);
        ay = $urandom_range(239, 0);
      end else begin
        ax = int'($signed(10'($urandom)));
        ay = int'($signed(10'($urandom)));
      end
      send_item(aim_item(10'(ax), 10'(ay)));
      n = $urandom_range(40, 4);
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) send_item(near_pixel(ax, ay));
        else if (pick < 80) send_item(pixel_item(8'($urandom), 8'($urandom), 6'($urandom)));
        else if (pick < 85) send_item(read_item($urandom_range(3, 0) != 0));
        else if (pick < 88) send_item(trigger_item(1'($urandom)));
        else if (pick < 91)
          send_item(spare_item(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST))));
        else if (pick < 94) begin
          ax = $urandom_range(255, 0);
          ay = $urandom_range(239, 0);
          send_item(aim_item(10'(ax), 10'(ay)));
        end else send_item(spare_item(3'($urandom)));
      end
      send_item(frame_end_item());
      if ($urandom_range(3, 0) == 0) send_item(trigger_item(1'($urandom)));
      n = $urandom_range(3, 1);
      for (k = 0; k < n; k++) send_item(read_item($urandom_range(3, 0) != 0));
    end
  endtask

  // One long frame of white pixels inside the window drives the count into saturation.
  task automatic saturate_count();
    int k;
    send_item(aim_item(10'sd100, 10'sd100));
    send_item(trigger_item(1'b1));
    for (k = 0; k < 530; k++)
      send_item(pixel_item(8'(92 + $urandom_range(15, 0)), 8'(92 + $urandom_range(15, 0)),
                           6'($urandom_range(45, 32))));
    send_item(frame_end_item());
    send_item(read_item(1'b1));
    send_item(trigger_item(1'b0));
    send_item(read_item(1'b1));
    send_item(read_item(1'b0));
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) hold_left--;
      else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("status byte %02h with no read pending", out_read_data));
      end else begin
        want = status_q.pop_front();
        if (out_read_data !== want.data)
          report_mismatch($sformatf("read_data %02h, expected %02h", out_read_data, want.data));
        if (out_light_seen !== want.light)
          report_mismatch($sformatf("light_seen %0b, expected %0b", out_light_seen,
                                    want.light));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[light_gun_hit_detector] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    row_t script [NUM_ROWS];
    int i;
    script = '{
      known_read(1'b1, lghd_pkg::STATUS_NO_LIGHT, 1'b0),
      quiet_row(trigger_item(1'b1)),
      known_read(1'b1, lghd_pkg::STATUS_TRIGGER | lghd_pkg::STATUS_NO_LIGHT, 1'b0),
      quiet_row(aim_item(-10'sd512, -10'sd512)),
      quiet_row(pixel_item(8'd0, 8'd0, 6'h20)),
      quiet_row(aim_item(10'sd511, 10'sd511)),
      quiet_row(pixel_item(8'd255, 8'd255, 6'h3F)),
      quiet_row(aim_item(10'sd255, 10'sd239)),
      quiet_row(pixel_item(8'd255, 8'd239, 6'h00)),
      quiet_row(pixel_item(8'd247, 8'd231, 6'h30)),
      quiet_row(pixel_item(8'd246, 8'd231, 6'h30)),
      quiet_row(pixel_item(8'd250, 8'd240, 6'h20)),
      quiet_row(spare_item(KIND_SPARE_LAST)),
      quiet_row(frame_end_item()),
      quiet_row(read_item(1'b0)),
      quiet_row(trigger_item(1'b0)),
      known_read(1'b1, lghd_pkg::STATUS_NO_LIGHT, 1'b0),
      quiet_row(aim_item(10'sd0, 10'sd0)),
      quiet_row(pixel_item(8'd0, 8'd0, 6'h3F)),
      quiet_row(pixel_item(8'd7, 8'd7, 6'h10)),
      quiet_row(aim_item(-10'sd1, -10'sd1)),
      quiet_row(pixel_item(8'd6, 8'd6, 6'h2D)),
      quiet_row(frame_end_item()),
      known_read(1'b1, lghd_pkg::STATUS_NO_LIGHT, 1'b0)
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < NUM_ROWS; i++)
      send_item(script[i].s, script[i].typed, script[i].data, script[i].light);

    set_threshold(9'd0);
    hold_off_req = 1'b1;
    run_frames(160);

    set_threshold(9'd256);
    send_idle_pct = IDLE_BOTH;
    stall_pct = IDLE_BOTH;
    saturate_count();

    set_threshold(9'($urandom_range(24, 0)));
    send_idle_pct = IDLE_HEAVY;
    stall_pct = 0;
    run_frames(160);

    set_threshold(9'($urandom_range(24, 0)));
    send_idle_pct = 0;
    stall_pct = IDLE_HEAVY;
    run_frames(160);

    set_threshold(lghd_pkg::THRESHOLD_RESET);
    send_idle_pct = IDLE_BOTH;
    stall_pct = IDLE_BOTH;
    run_frames(100);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[light_gun_hit_detector] OK");
    else
      $display("[light_gun_hit_detector] ERROR");
    $finish;
  end

endmodule
